FILE: design/sida_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the controller state type, command/status structs and character constants.
// No dependencies.
package sida_pkg;

    // Input bits folded into the BCD register per conversion cycle
    localparam int BITS_PER_STEP = 4;

    // ASCII codes, cut to the 6-bit output character field
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic count;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic conv_last;
        logic neg;
        logic last_digit;
        logic out_free;
    } t_stat;

endpackage

FILE: design/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII: one character beat per cycle while the receiver is ready,
// MSD first, '-' for negatives. After accept, shift-add-3 steps convert four bits each, the
// leading digit is located, then the sign and digits go through the character output register.
// A new value is accepted only after the last digit of the previous one has been registered,
// so the 4-bit-per-cycle BCD converter and the single character output register set the rate.
// Reset (synchronous, active low) returns the controller to idle and empties the output register.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [5:0]                   o_text_char,
    output logic                         o_is_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    sida_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Conversion and output datapath
    sida_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_text_char (o_text_char),
        .o_is_last   (o_is_last)
    );

endmodule

FILE: design/sida_dp.sv
// Datapath: magnitude register, shift-add-3 BCD converter, digit selector and output beat register.
// Depends on sida_pkg.
module sida_dp
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_out_ready,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    output logic                         o_out_valid,
    output logic [5:0]                   o_text_char,
    output logic                         o_is_last
);

    localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD   = STEPS * BITS_PER_STEP;
    // Decimal digits needed for VALUE_BITS of magnitude (log10(2) ~ 0.30103)
    localparam int ND    = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCDW  = ND * 4;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int DW    = $clog2(ND);

    logic [PAD-1:0]        r_mag,      n_mag;
    logic [BCDW-1:0]       r_bcd,      n_bcd;
    logic                  r_neg,      n_neg;
    logic [CW-1:0]         r_step_cnt, n_step_cnt;
    logic [DW-1:0]         r_idx,      n_idx;
    logic                  r_valid,    n_valid;
    logic [5:0]            r_char,     n_char;
    logic                  r_last,     n_last;

    logic [VALUE_BITS-1:0] w_v;
    logic [VALUE_BITS-1:0] w_mag;
    logic [BCDW-1:0]       w_bcd_step;
    logic [3:0]            w_digits [ND];
    logic [DW-1:0]         w_top;
    logic                  w_out_free;

    // Magnitude as unsigned, so the most negative value converts exactly
    assign w_v   = $unsigned(i_value);
    assign w_mag = w_v[VALUE_BITS-1] ? (VALUE_BITS'(0) - w_v) : w_v;

    // Four shift-add-3 steps, one magnitude bit each, MSB first
    always_comb begin
        w_bcd_step = r_bcd;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int d = 0; d < ND; d++) begin
                if (w_bcd_step[d*4 +: 4] >= 4'd5) begin
                    w_bcd_step[d*4 +: 4] = w_bcd_step[d*4 +: 4] + 4'd3;
                end
            end
            w_bcd_step = {w_bcd_step[BCDW-2:0], r_mag[PAD-1-b]};
        end
    end

    // Digit view of the BCD register
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            w_digits[d] = r_bcd[d*4 +: 4];
        end
    end

    // Highest non-zero digit; zero itself gives digit 0
    always_comb begin
        w_top = '0;
        for (int d = 0; d < ND; d++) begin
            if (w_digits[d] != 4'd0) begin
                w_top = DW'(d);
            end
        end
    end

    assign w_out_free = !r_valid || i_out_ready;

    // Next-state for all datapath registers
    always_comb begin
        n_mag      = r_mag;
        n_bcd      = r_bcd;
        n_neg      = r_neg;
        n_step_cnt = r_step_cnt;
        n_idx      = r_idx;
        n_valid    = r_valid && !i_out_ready;
        n_char     = r_char;
        n_last     = r_last;
        if (i_cmd.load) begin
            n_mag      = PAD'(w_mag);
            n_bcd      = '0;
            n_neg      = w_v[VALUE_BITS-1];
            n_step_cnt = CW'(STEPS);
        end
        if (i_cmd.step) begin
            n_mag      = r_mag << BITS_PER_STEP;
            n_bcd      = w_bcd_step;
            n_step_cnt = r_step_cnt - 1'b1;
        end
        if (i_cmd.count) begin
            n_idx = w_top;
        end
        if (i_cmd.emit_sign) begin
            n_valid = 1'b1;
            n_char  = CHAR_MINUS;
            n_last  = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_valid = 1'b1;
            n_char  = CHAR_ZERO + {2'b00, w_digits[r_idx]};
            n_last  = (r_idx == '0);
            n_idx   = r_idx - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_step_cnt <= '0;
        end else begin
            r_valid    <= n_valid;
            r_step_cnt <= n_step_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stat.conv_last  = (r_step_cnt == CW'(1));
    assign o_stat.neg        = r_neg;
    assign o_stat.last_digit = (r_idx == '0);
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid = r_valid;
    assign o_text_char = r_char;
    assign o_is_last   = r_last;

    // A conversion step never runs past its bit count
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_step_cnt != '0)
        else $error("conversion step with no bits left");

    // Every digit beat carries an ASCII digit
    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |=> (r_char >= CHAR_ZERO) && (r_char <= CHAR_ZERO + 6'd9))
        else $error("digit beat outside '0'..'9'");

    // Leading digit found is non-zero unless the number is a single digit
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count |=> (r_idx == '0) || (w_digits[r_idx] != 4'd0))
        else $error("leading zero not suppressed");

endmodule

FILE: design/sida_ctrl.sv
// Controller state machine: load, convert, locate leading digit, emit sign and digits.
// Depends on sida_pkg.
module sida_ctrl
    import sida_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_stat.conv_last) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = i_stat.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Last digit beat always returns to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_digit && i_stat.last_digit) |=> r_state == ST_IDLE)
        else $error("controller did not return to idle after last digit");

endmodule

FILE: verif/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for signed_int_to_decimal_ascii: drives signed integers, predicts
// their decimal ASCII character beats and compares them in order as they leave the block.
// Depends on sida_pkg and the signed_int_to_decimal_ascii RTL only.
module signed_int_to_decimal_ascii_tb
    import sida_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS     = 32;
    localparam int NUM_DIRECTED   = 22;
    localparam int NUM_RANDOM     = 390;
    localparam int CALM_TAIL      = 60;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 50;

    // One expected character beat
    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } t_char_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic signed [VALUE_BITS-1:0] i_value = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [5:0]                   o_text_char;
    logic                         o_is_last;

    t_char_beat expected_chars[$];
    string      value_text = "";
    bit         no_idle = 1'b0;
    int         err_count = 0;
    int         quiet_cycles = 0;
    int         stall_left = 0;

    // Directed values; a non-empty text is the known answer, otherwise the predictor decides
    logic [VALUE_BITS-1:0] dir_value [NUM_DIRECTED] = '{
        32'sd0, 32'sd2147483647, 32'h8000_0000, -32'sd1, 32'sd1,
        32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99,
        32'sd100, -32'sd100, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
        -32'sd2147483647, 32'sd2147483646, 32'sd12345, -32'sd67890, 32'h5555_5555,
        32'hAAAA_AAAA, 32'sd7
    };
    string dir_text [NUM_DIRECTED] = '{
        "0", "2147483647", "-2147483648", "-1", "1",
        "", "", "", "", "",
        "", "", "", "", "",
        "", "", "", "", "",
        "", ""
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_text_char(o_text_char),
        .o_is_last  (o_is_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected characters of one value: sign, then digits most significant first
    function automatic void push_decimal_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits [24];
        int                    nd;
        t_char_beat            beat;
        nd  = 0;
        mag = value[VALUE_BITS-1] ? ('0 - value) : value;
        do begin
            digits[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        if (value[VALUE_BITS-1]) begin
            beat.ch   = CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            beat.ch   = CHAR_ZERO + 6'(digits[i]);
            beat.last = (i == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    // Known answer typed as text
    function automatic void push_typed_text(input string txt);
        t_char_beat beat;
        for (int i = 0; i < txt.len(); i++) begin
            beat.ch   = 6'(txt[i]);
            beat.last = (i == txt.len() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Sample both channels at the rising edge; input beats first, then output beats
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (value_text.len() != 0)
                    push_typed_text(value_text);
                else
                    push_decimal_text(i_value);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected character beat", o_text_char, -1);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_text_char !== want.ch)
                        report_mismatch("text_char", o_text_char, want.ch);
                    if (o_is_last !== want.last)
                        report_mismatch("is_last", o_is_last, want.last);
                end
            end
            // Watchdog on cycles with no beat on either channel
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one value, with an optional idle burst first, and hold it until accepted
    task automatic send_value(input logic [VALUE_BITS-1:0] value, input string txt);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        value_text = txt;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending until every outstanding character has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Random value: mostly a uniform digit count, some raw bit patterns and edge values
    function automatic logic [VALUE_BITS-1:0] random_value();
        longint lo;
        longint hi;
        int     nd;
        bit     neg;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 5))
                    0: return '0;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h8000_0001;
                    4: return '1;
                    default: return 32'd1;
                endcase
            end
            default: begin
                nd  = $urandom_range(1, 10);
                neg = $urandom_range(0, 1);
                lo  = 1;
                for (int i = 1; i < nd; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (nd == 1) lo = 0;
                if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
                lo = $urandom_range(32'(hi), 32'(lo));
                return neg ? 32'(-lo) : 32'(lo);
            end
        endcase
    endfunction

    initial begin
        // Synchronous reset, released on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(dir_value[i], dir_text[i]);
        wait_drained();

        // Random part, with one more full drain halfway and a calm tail
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM / 2)
                wait_drained();
            if (i == NUM_RANDOM - CALM_TAIL)
                no_idle = 1'b1;
            send_value(random_value(), "");
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
design/sida_pkg.sv
design/sida_dp.sv
design/sida_ctrl.sv
design/signed_int_to_decimal_ascii.sv
verif/signed_int_to_decimal_ascii_tb.sv
